// File: rtl/core/rehc_pkg.sv
// ============================================================================
// Read error histogram counter package
// Shared types, constants and symbol helpers for the histogram counter.
// ============================================================================
`default_nettype none

package rehc_pkg;

    localparam int DEF_NUM_FILES      = 4;
    localparam int DEF_QUALITY_LEVELS = 64;
    localparam int DEF_TARGETS        = 4;
    localparam int DEF_MAX_COVERAGE   = 255;
    localparam int DEF_COUNT_BITS     = 32;

    localparam int PAIRS     = 36;
    localparam int SYM_KINDS = 6;
    localparam int COV_W     = 16;
    localparam int OP_DEPTH  = 4;
    localparam int OUT_DEPTH = 4;
    localparam int SLOTS     = 4;

    localparam logic [2:0] SYM_N   = 3'd4;
    localparam logic [2:0] SYM_GAP = 3'd5;

    typedef enum logic [1:0] {
        ALIGN_BASE      = 2'd0,
        ALIGN_DEL       = 2'd1,
        ALIGN_REDUNDANT = 2'd2,
        ALIGN_UNUSED    = 2'd3
    } t_align_kind;

    typedef enum logic {
        UPD_ERROR    = 1'b0,
        UPD_COVERAGE = 1'b1
    } t_update_kind;

    typedef struct packed {
        t_update_kind     kind;
        logic [1:0]       file;
        logic [5:0]       quality;
        logic [2:0]       first;
        logic [2:0]       second;
        logic [COV_W-1:0] cov;
        logic             last;
    } t_op;

    typedef struct packed {
        t_update_kind kind;
        logic [1:0]   file;
        logic [5:0]   quality;
        logic [2:0]   first;
        logic [2:0]   second;
        logic [7:0]   cov;
        logic [31:0]  count;
        logic         last;
    } t_result;

    function automatic logic [2:0] norm_sym(input logic [2:0] s);
        return (s >= SYM_N) ? SYM_N : s;
    endfunction

    function automatic logic [2:0] complement_sym(input logic [2:0] s);
        return (s < SYM_N) ? 3'(3'd3 - s) : s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rehc_in_if.sv
// ============================================================================
// Read item channel
// Carries one aligned read at a pileup position with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface rehc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        align_kind;
    logic signed [7:0] indel_len;
    logic              reverse_strand;
    logic [2:0]        ref_symbol;
    logic [2:0]        read_symbol;
    logic [2:0]        following_symbol;
    logic [5:0]        base_quality;
    logic [5:0]        following_quality;
    logic              has_following;
    logic [1:0]        file_index;
    logic [1:0]        target_index;
    logic              last_of_position;

    modport source (
        output valid, align_kind, indel_len, reverse_strand, ref_symbol, read_symbol,
               following_symbol, base_quality, following_quality, has_following,
               file_index, target_index, last_of_position,
        input  ready
    );

    modport sink (
        input  valid, align_kind, indel_len, reverse_strand, ref_symbol, read_symbol,
               following_symbol, base_quality, following_quality, has_following,
               file_index, target_index, last_of_position,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/rehc_out_if.sv
// ============================================================================
// Histogram update channel
// Carries one histogram bin update and its new count with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface rehc_out_if;
    logic        valid;
    logic        ready;
    logic        update_kind;
    logic [1:0]  bin_file;
    logic [5:0]  bin_quality;
    logic [2:0]  first_symbol;
    logic [2:0]  second_symbol;
    logic [7:0]  coverage_value;
    logic [31:0] new_count;
    logic        last_result;

    modport source (
        output valid, update_kind, bin_file, bin_quality, first_symbol, second_symbol,
               coverage_value, new_count, last_result,
        input  ready
    );

    modport sink (
        input  valid, update_kind, bin_file, bin_quality, first_symbol, second_symbol,
               coverage_value, new_count, last_result,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/rehc_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ============================================================================
`default_nettype none

module rehc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/rehc_fifo.sv
// ============================================================================
// Small register queue
// First-in first-out buffer with valid/ready on both sides and a fill count.
// ============================================================================
`default_nettype none

module rehc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [WIDTH-1:0]           i_data,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [WIDTH-1:0]           o_data,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             push;
    logic             pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : PW'(r_wp + 1'b1);
        end
        if (pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : PW'(r_rp + 1'b1);
        end
        if (push && !pop) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (pop && !push) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rehc_front.sv
// ============================================================================
// Histogram counter front end
// Accepts reads, classifies them into bin updates and tracks position coverage.
// ============================================================================
`default_nettype none

module rehc_front #(
    parameter int NUM_FILES      = rehc_pkg::DEF_NUM_FILES,
    parameter int QUALITY_LEVELS = rehc_pkg::DEF_QUALITY_LEVELS,
    parameter int TARGETS        = rehc_pkg::DEF_TARGETS,
    parameter int MAX_COVERAGE   = rehc_pkg::DEF_MAX_COVERAGE
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rehc_in_if.sink            i_in,
    input  wire logic          i_clear_busy,
    output logic               o_op_valid,
    input  wire logic          i_op_ready,
    output rehc_pkg::t_op      o_op
);

    localparam int PCW = $clog2(MAX_COVERAGE + 1);
    localparam int NS  = rehc_pkg::SLOTS;

    logic [PCW-1:0]          r_pos_cov, n_pos_cov;
    logic                    r_red, n_red;
    logic [NS-1:0]           r_mask, n_mask;
    rehc_pkg::t_op           r_slot [NS];
    rehc_pkg::t_op           new_slot [NS];
    logic [NS-1:0]           new_mask;
    logic [NS-1:0]           sel;
    logic                    accept;

    rehc_pkg::t_align_kind   kind;
    logic                    is_base;
    logic                    is_del;
    logic                    is_red;
    logic [2:0]              ref_n;
    logic [2:0]              rd_n;
    logic [2:0]              nxt_n;
    logic [2:0]              ref_side;
    logic [2:0]              rd_side;
    logic [1:0]              file_c;
    logic [1:0]              tgt_c;
    logic [5:0]              bq_c;
    logic [5:0]              fq_c;
    logic [6:0]              avg_sum;
    logic [5:0]              avg_c;
    logic [PCW-1:0]          pos_next;
    logic                    red_now;

    always_comb begin
        kind    = rehc_pkg::t_align_kind'(i_in.align_kind);
        is_base = 1'b0;
        is_del  = 1'b0;
        is_red  = 1'b0;
        unique case (kind)
            rehc_pkg::ALIGN_BASE:      is_base = 1'b1;
            rehc_pkg::ALIGN_DEL:       is_del  = 1'b1;
            rehc_pkg::ALIGN_REDUNDANT: is_red  = 1'b1;
            rehc_pkg::ALIGN_UNUSED:    is_red  = 1'b1;
            default:                   is_red  = 1'b1;
        endcase

        ref_n    = rehc_pkg::norm_sym(i_in.ref_symbol);
        rd_n     = rehc_pkg::norm_sym(i_in.read_symbol);
        nxt_n    = rehc_pkg::norm_sym(i_in.following_symbol);
        ref_side = i_in.reverse_strand ? rehc_pkg::complement_sym(ref_n) : ref_n;
        rd_side  = i_in.reverse_strand ? rehc_pkg::complement_sym(rd_n) : rd_n;

        file_c  = (int'(i_in.file_index) >= NUM_FILES) ? 2'(NUM_FILES - 1)
                                                       : i_in.file_index;
        tgt_c   = (int'(i_in.target_index) >= TARGETS) ? 2'(TARGETS - 1)
                                                       : i_in.target_index;
        bq_c    = (int'(i_in.base_quality) >= QUALITY_LEVELS) ? 6'(QUALITY_LEVELS - 1)
                                                              : i_in.base_quality;
        fq_c    = (int'(i_in.following_quality) >= QUALITY_LEVELS)
                  ? 6'(QUALITY_LEVELS - 1) : i_in.following_quality;
        avg_sum = 7'(i_in.base_quality) + 7'(i_in.following_quality);
        avg_c   = (int'(avg_sum[6:1]) >= QUALITY_LEVELS) ? 6'(QUALITY_LEVELS - 1)
                                                         : avg_sum[6:1];

        pos_next = r_pos_cov;
        if (is_base && (r_pos_cov < PCW'(MAX_COVERAGE))) begin
            pos_next = PCW'(r_pos_cov + 1'b1);
        end
        red_now = r_red || is_red;

        new_mask[0] = (is_base && (rd_n != rehc_pkg::SYM_N))
                   || (is_del && (i_in.indel_len == 8'sd0));
        new_mask[1] = is_base && (rd_n != rehc_pkg::SYM_N) && i_in.has_following;
        new_mask[2] = !is_red && !(is_base && (rd_n == rehc_pkg::SYM_N))
                   && (i_in.indel_len == 8'sd1) && (nxt_n != rehc_pkg::SYM_N);
        new_mask[3] = i_in.last_of_position && !red_now;

        new_slot[0].kind    = rehc_pkg::UPD_ERROR;
        new_slot[0].file    = file_c;
        new_slot[0].quality = (is_del && !i_in.reverse_strand) ? fq_c : bq_c;
        new_slot[0].first   = ref_side;
        new_slot[0].second  = is_del ? rehc_pkg::SYM_GAP : rd_side;
        new_slot[0].cov     = '0;
        new_slot[0].last    = new_mask[0] && (new_mask[3:1] == '0);

        new_slot[1].kind    = rehc_pkg::UPD_ERROR;
        new_slot[1].file    = file_c;
        new_slot[1].quality = avg_c;
        new_slot[1].first   = rehc_pkg::SYM_GAP;
        new_slot[1].second  = rehc_pkg::SYM_GAP;
        new_slot[1].cov     = '0;
        new_slot[1].last    = new_mask[1] && (new_mask[3:2] == '0);

        new_slot[2].kind    = rehc_pkg::UPD_ERROR;
        new_slot[2].file    = file_c;
        new_slot[2].quality = fq_c;
        new_slot[2].first   = rehc_pkg::SYM_GAP;
        new_slot[2].second  = nxt_n;
        new_slot[2].cov     = '0;
        new_slot[2].last    = new_mask[2] && !new_mask[3];

        new_slot[3].kind    = rehc_pkg::UPD_COVERAGE;
        new_slot[3].file    = tgt_c;
        new_slot[3].quality = '0;
        new_slot[3].first   = '0;
        new_slot[3].second  = '0;
        new_slot[3].cov     = rehc_pkg::COV_W'(pos_next);
        new_slot[3].last    = new_mask[3];
    end

    always_comb begin
        sel        = r_mask & NS'(~r_mask + 1'b1);
        o_op_valid = (r_mask != '0);
        o_op       = r_slot[3];
        priority if (sel[0]) begin
            o_op = r_slot[0];
        end else if (sel[1]) begin
            o_op = r_slot[1];
        end else if (sel[2]) begin
            o_op = r_slot[2];
        end else begin
            o_op = r_slot[3];
        end

        n_mask = (o_op_valid && i_op_ready) ? (r_mask & ~sel) : r_mask;
        i_in.ready = (n_mask == '0) && !i_clear_busy;
        accept     = i_in.valid && i_in.ready;

        n_pos_cov = r_pos_cov;
        n_red     = r_red;
        if (accept) begin
            n_mask = new_mask;
            if (i_in.last_of_position) begin
                n_pos_cov = '0;
                n_red     = 1'b0;
            end else begin
                n_pos_cov = pos_next;
                n_red     = red_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_pos_cov <= '0;
            r_red     <= 1'b0;
        end else begin
            r_mask    <= n_mask;
            r_pos_cov <= n_pos_cov;
            r_red     <= n_red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot <= new_slot;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rehc_back.sv
// ============================================================================
// Histogram counter back end
// Read-modify-write of error and coverage bins, one update a cycle unless held.
// ============================================================================
`default_nettype none

module rehc_back #(
    parameter int NUM_FILES      = rehc_pkg::DEF_NUM_FILES,
    parameter int QUALITY_LEVELS = rehc_pkg::DEF_QUALITY_LEVELS,
    parameter int TARGETS        = rehc_pkg::DEF_TARGETS,
    parameter int MAX_COVERAGE   = rehc_pkg::DEF_MAX_COVERAGE,
    parameter int COUNT_BITS     = rehc_pkg::DEF_COUNT_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_op_valid,
    output logic               o_op_ready,
    input  wire rehc_pkg::t_op i_op,
    output logic               o_clear_busy,
    rehc_out_if.source         o_out
);

    localparam int E_DEPTH   = NUM_FILES * QUALITY_LEVELS * rehc_pkg::PAIRS;
    localparam int C_DEPTH   = TARGETS * (MAX_COVERAGE + 1);
    localparam int EAW       = $clog2(E_DEPTH);
    localparam int CAW       = $clog2(C_DEPTH);
    localparam int CLR_DEPTH = (E_DEPTH > C_DEPTH) ? E_DEPTH : C_DEPTH;
    localparam int CLW       = $clog2(CLR_DEPTH);
    localparam int OCW       = $clog2(rehc_pkg::OUT_DEPTH + 1);
    localparam int RW        = $bits(rehc_pkg::t_result);

    logic                  r_clr_busy;
    logic [CLW-1:0]        r_clr_idx;

    logic                  issue;
    logic [EAW-1:0]        a_eaddr;
    logic [CAW-1:0]        a_caddr;
    logic [OCW:0]          occupancy;

    logic                  r_b_valid;
    rehc_pkg::t_op         r_b_op;
    logic [EAW-1:0]        r_b_eaddr;
    logic [CAW-1:0]        r_b_caddr;

    logic                  r_fwd_valid;
    rehc_pkg::t_update_kind r_fwd_kind;
    logic [EAW-1:0]        r_fwd_eaddr;
    logic [CAW-1:0]        r_fwd_caddr;
    logic [COUNT_BITS-1:0] r_fwd_cnt;

    logic [COUNT_BITS-1:0] e_rdata;
    logic [COUNT_BITS-1:0] c_rdata;
    logic [COUNT_BITS-1:0] cnt_in;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [63:0]           cnt_wide;
    logic                  fwd_hit;

    logic                  e_we;
    logic [EAW-1:0]        e_waddr;
    logic                  c_we;
    logic [CAW-1:0]        c_waddr;
    logic [COUNT_BITS-1:0] wdata;

    rehc_pkg::t_result     res;
    rehc_pkg::t_result     out_res;
    logic [RW-1:0]         out_bits;
    logic [OCW-1:0]        out_count;

    always_comb begin
        a_eaddr   = EAW'((int'(i_op.file) * QUALITY_LEVELS + int'(i_op.quality))
                         * rehc_pkg::PAIRS + int'(i_op.first) * rehc_pkg::SYM_KINDS
                         + int'(i_op.second));
        a_caddr   = CAW'(int'(i_op.file) * (MAX_COVERAGE + 1) + int'(i_op.cov));
        occupancy = (OCW + 1)'(out_count) + (OCW + 1)'(r_b_valid);
        issue     = i_op_valid && !r_clr_busy
                 && (occupancy < (OCW + 1)'(rehc_pkg::OUT_DEPTH));
        o_op_ready   = issue;
        o_clear_busy = r_clr_busy;
    end

    always_comb begin
        if (r_b_op.kind == rehc_pkg::UPD_ERROR) begin
            fwd_hit = r_fwd_valid && (r_fwd_kind == rehc_pkg::UPD_ERROR)
                   && (r_fwd_eaddr == r_b_eaddr);
            cnt_in  = fwd_hit ? r_fwd_cnt : e_rdata;
        end else begin
            fwd_hit = r_fwd_valid && (r_fwd_kind == rehc_pkg::UPD_COVERAGE)
                   && (r_fwd_caddr == r_b_caddr);
            cnt_in  = fwd_hit ? r_fwd_cnt : c_rdata;
        end
        cnt_new  = (cnt_in == '1) ? cnt_in : COUNT_BITS'(cnt_in + 1'b1);
        cnt_wide = 64'(cnt_new);

        if (r_clr_busy) begin
            e_we    = int'(r_clr_idx) < E_DEPTH;
            c_we    = int'(r_clr_idx) < C_DEPTH;
            e_waddr = r_clr_idx[EAW-1:0];
            c_waddr = r_clr_idx[CAW-1:0];
            wdata   = '0;
        end else begin
            e_we    = r_b_valid && (r_b_op.kind == rehc_pkg::UPD_ERROR);
            c_we    = r_b_valid && (r_b_op.kind == rehc_pkg::UPD_COVERAGE);
            e_waddr = r_b_eaddr;
            c_waddr = r_b_caddr;
            wdata   = cnt_new;
        end

        res.kind    = r_b_op.kind;
        res.file    = r_b_op.file;
        res.quality = r_b_op.quality;
        res.first   = r_b_op.first;
        res.second  = r_b_op.second;
        res.cov     = r_b_op.cov[7:0];
        res.count   = cnt_wide[31:0];
        res.last    = r_b_op.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= CLW'(r_clr_idx + 1'b1);
                if (r_clr_idx == CLW'(CLR_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_b_valid   <= issue;
            r_fwd_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_op    <= i_op;
            r_b_eaddr <= a_eaddr;
            r_b_caddr <= a_caddr;
        end
        r_fwd_kind  <= r_b_op.kind;
        r_fwd_eaddr <= r_b_eaddr;
        r_fwd_caddr <= r_b_caddr;
        r_fwd_cnt   <= cnt_new;
    end

    rehc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (E_DEPTH)
    ) u_error_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (wdata),
        .i_raddr (a_eaddr),
        .o_rdata (e_rdata)
    );

    rehc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (C_DEPTH)
    ) u_cover_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (wdata),
        .i_raddr (a_caddr),
        .o_rdata (c_rdata)
    );

    rehc_fifo #(
        .WIDTH (RW),
        .DEPTH (rehc_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_valid),
        .o_ready (),
        .i_data  (RW'(res)),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (out_bits),
        .o_count (out_count)
    );

    always_comb begin
        out_res             = rehc_pkg::t_result'(out_bits);
        o_out.update_kind   = out_res.kind;
        o_out.bin_file      = out_res.file;
        o_out.bin_quality   = out_res.quality;
        o_out.first_symbol  = out_res.first;
        o_out.second_symbol = out_res.second;
        o_out.coverage_value = out_res.cov;
        o_out.new_count     = out_res.count;
        o_out.last_result   = out_res.last;
    end

endmodule

`default_nettype wire

// File: rtl/core/read_error_histogram_counter.sv
// ============================================================================
// Read error histogram counter
// Classifies aligned reads into error and coverage histogram updates.
// ============================================================================
// Reads enter on i_in, one aligned read at a pileup position per request.
// Each read is turned into up to four histogram updates: a substitution or
// match, a gap pair, a single-base deletion or insertion, and on the last read
// of a position a coverage bin. Every update leaves on o_out with its new
// saturated count, and the final update of a read carries last_result.
// The histogram memories each have one write port, so the back end retires one
// update per cycle unless o_out stalls; a read holds i_in.ready low until each
// of its updates has gone on. A read producing a single update is taken every
// cycle while nothing stalls. o_out.valid for its first update rises once it
// has passed the slot register, update queue, back-end stage and result queue.
// After reset a clearing pass zeroes both histograms, stepping through every
// entry of the larger memory (9216 with the default sizes); i_in.ready stays
// low until it finishes. When o_out stalls, a four-entry result queue and a
// four-entry update queue fill up before i_in.ready drops.
// ============================================================================
`default_nettype none

module read_error_histogram_counter #(
    parameter int NUM_FILES      = rehc_pkg::DEF_NUM_FILES,
    parameter int QUALITY_LEVELS = rehc_pkg::DEF_QUALITY_LEVELS,
    parameter int TARGETS        = rehc_pkg::DEF_TARGETS,
    parameter int MAX_COVERAGE   = rehc_pkg::DEF_MAX_COVERAGE,
    parameter int COUNT_BITS     = rehc_pkg::DEF_COUNT_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rehc_in_if.sink    i_in,
    rehc_out_if.source o_out
);

    localparam int OPW = $bits(rehc_pkg::t_op);

    logic           clear_busy;
    logic           f_valid;
    logic           f_ready;
    rehc_pkg::t_op  f_op;
    logic           q_valid;
    logic           q_ready;
    logic [OPW-1:0] q_bits;

    rehc_front #(
        .NUM_FILES      (NUM_FILES),
        .QUALITY_LEVELS (QUALITY_LEVELS),
        .TARGETS        (TARGETS),
        .MAX_COVERAGE   (MAX_COVERAGE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_clear_busy (clear_busy),
        .o_op_valid   (f_valid),
        .i_op_ready   (f_ready),
        .o_op         (f_op)
    );

    rehc_fifo #(
        .WIDTH (OPW),
        .DEPTH (rehc_pkg::OP_DEPTH)
    ) u_op_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (OPW'(f_op)),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_bits),
        .o_count ()
    );

    rehc_back #(
        .NUM_FILES      (NUM_FILES),
        .QUALITY_LEVELS (QUALITY_LEVELS),
        .TARGETS        (TARGETS),
        .MAX_COVERAGE   (MAX_COVERAGE),
        .COUNT_BITS     (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (q_valid),
        .o_op_ready   (q_ready),
        .i_op         (rehc_pkg::t_op'(q_bits)),
        .o_clear_busy (clear_busy),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

// File: sim/read_error_histogram_counter_test.sv
// ============================================================================
// Read error histogram counter testbench
// Sends aligned reads through the input channel and checks each histogram
// update, field by field and in order, against a model kept in this bench.
// Directed reads, output hold-off, coverage saturation and random pileups
// are run in turn.
// ============================================================================

module read_error_histogram_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FILES      = rehc_pkg::DEF_NUM_FILES;
    localparam int QUALITY_LEVELS = rehc_pkg::DEF_QUALITY_LEVELS;
    localparam int TARGETS        = rehc_pkg::DEF_TARGETS;
    localparam int MAX_COVERAGE   = rehc_pkg::DEF_MAX_COVERAGE;
    localparam int COUNT_BITS     = rehc_pkg::DEF_COUNT_BITS;
    localparam int COV_BINS       = MAX_COVERAGE + 1;
    localparam int ERROR_BINS     = NUM_FILES * QUALITY_LEVELS * rehc_pkg::PAIRS;

    localparam logic [63:0] COUNT_TOP = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_BITS);

    localparam rehc_pkg::t_align_kind KIND_BASE      = rehc_pkg::ALIGN_BASE;
    localparam rehc_pkg::t_align_kind KIND_DEL       = rehc_pkg::ALIGN_DEL;
    localparam rehc_pkg::t_align_kind KIND_REDUNDANT = rehc_pkg::ALIGN_REDUNDANT;
    localparam rehc_pkg::t_align_kind KIND_UNUSED    = rehc_pkg::ALIGN_UNUSED;

    localparam logic [2:0] SYM_A    = 3'd0;
    localparam logic [2:0] SYM_C    = 3'd1;
    localparam logic [2:0] SYM_G    = 3'd2;
    localparam logic [2:0] SYM_T    = 3'd3;
    localparam logic [2:0] SYM_N    = rehc_pkg::SYM_N;
    localparam logic [2:0] SYM_GAP  = rehc_pkg::SYM_GAP;
    localparam logic [2:0] SYM_JUNK = 3'd7;

    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int LONG_HOLD     = 80;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_READS    = 24;
    localparam int DEEP_READS    = 260;
    localparam int RANDOM_READS  = 155;
    localparam int CALM_READS    = 40;

    typedef struct {
        rehc_pkg::t_align_kind kind;
        logic signed [7:0]     indel;
        logic                  rev;
        logic [2:0]            ref_sym;
        logic [2:0]            read_sym;
        logic [2:0]            next_sym;
        logic [5:0]            bq;
        logic [5:0]            fq;
        logic                  has_next;
        logic [1:0]            file;
        logic [1:0]            target;
        logic                  last;
    } t_read;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rehc_in_if  in_ch ();
    rehc_out_if out_ch ();

    read_error_histogram_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [63:0]       error_bins [ERROR_BINS];
    logic [63:0]       coverage_bins [TARGETS * COV_BINS];
    int unsigned       reads_here;
    bit                redundant_here;
    rehc_pkg::t_result item_updates [$];
    rehc_pkg::t_result pending_updates [$];

    int unsigned mismatch_total;
    int unsigned reads_sent;
    int unsigned updates_checked;
    int unsigned coverage_updates;
    int unsigned cycle_count;
    int unsigned hold_left;
    bit          gaps_on;
    bit          stalls_on;
    bit          long_hold_req;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d updates outstanding", cycle_count,
                     pending_updates.size());
            $display("read_error_histogram_counter_test: done, errors");
            $finish;
        end
    end

    function automatic logic [2:0] base_or_n(input logic [2:0] s);
        return (s > SYM_N) ? SYM_N : s;
    endfunction

    function automatic logic [2:0] opposite_base(input logic [2:0] s);
        case (s)
            SYM_A:   return SYM_T;
            SYM_C:   return SYM_G;
            SYM_G:   return SYM_C;
            SYM_T:   return SYM_A;
            default: return s;
        endcase
    endfunction

    function automatic void clear_histograms();
        foreach (error_bins[i]) error_bins[i] = '0;
        foreach (coverage_bins[i]) coverage_bins[i] = '0;
        reads_here     = 0;
        redundant_here = 1'b0;
    endfunction

    function automatic void note_error(input int unsigned file, input int unsigned qual,
                                       input logic [2:0] a, input logic [2:0] b);
        int unsigned       q;
        int unsigned       idx;
        rehc_pkg::t_result u;
        q   = (qual < QUALITY_LEVELS) ? qual : QUALITY_LEVELS - 1;
        idx = (file * QUALITY_LEVELS + q) * rehc_pkg::PAIRS + int'(a) * rehc_pkg::SYM_KINDS
              + int'(b);
        if (error_bins[idx] < COUNT_TOP) error_bins[idx]++;
        u         = '0;
        u.kind    = rehc_pkg::UPD_ERROR;
        u.file    = 2'(file);
        u.quality = 6'(q);
        u.first   = a;
        u.second  = b;
        u.count   = error_bins[idx][31:0];
        item_updates = {item_updates, u};
    endfunction

    function automatic void predict_updates(input t_read r);
        logic [2:0]        ref_b;
        logic [2:0]        read_b;
        logic [2:0]        next_b;
        logic [2:0]        ref_side;
        int unsigned       file;
        int unsigned       target;
        int unsigned       idx;
        bit                skip_rest;
        rehc_pkg::t_result u;
        item_updates.delete();
        ref_b     = base_or_n(r.ref_sym);
        read_b    = base_or_n(r.read_sym);
        next_b    = base_or_n(r.next_sym);
        file      = (r.file < NUM_FILES) ? r.file : NUM_FILES - 1;
        target    = (r.target < TARGETS) ? r.target : TARGETS - 1;
        skip_rest = 1'b0;
        if (r.kind == KIND_REDUNDANT || r.kind == KIND_UNUSED) begin
            redundant_here = 1'b1;
        end else begin
            ref_side = r.rev ? opposite_base(ref_b) : ref_b;
            if (r.kind == KIND_BASE) begin
                if (reads_here < MAX_COVERAGE) reads_here++;
                if (read_b == SYM_N) begin
                    skip_rest = 1'b1;
                end else begin
                    note_error(file, r.bq, ref_side, r.rev ? opposite_base(read_b) : read_b);
                    if (r.has_next) begin
                        note_error(file, (int'(r.bq) + int'(r.fq)) / 2, SYM_GAP, SYM_GAP);
                    end
                end
            end else if (r.indel == 0) begin
                note_error(file, r.rev ? r.bq : r.fq, ref_side, SYM_GAP);
            end
            if (!skip_rest && r.indel == 1 && next_b != SYM_N) begin
                note_error(file, r.fq, SYM_GAP, next_b);
            end
        end
        if (r.last) begin
            if (!redundant_here) begin
                idx = target * COV_BINS + reads_here;
                if (coverage_bins[idx] < COUNT_TOP) coverage_bins[idx]++;
                u       = '0;
                u.kind  = rehc_pkg::UPD_COVERAGE;
                u.file  = 2'(target);
                u.cov   = 8'(reads_here);
                u.count = coverage_bins[idx][31:0];
                item_updates = {item_updates, u};
            end
            reads_here     = 0;
            redundant_here = 1'b0;
        end
        if (item_updates.size() > 0) item_updates[item_updates.size() - 1].last = 1'b1;
        pending_updates = {pending_updates, item_updates};
    endfunction

    function automatic t_read make_read(input rehc_pkg::t_align_kind kind, input int indel,
                                        input logic rev, input logic [2:0] ref_sym,
                                        input logic [2:0] read_sym, input logic [2:0] next_sym,
                                        input int bq, input int fq, input logic has_next,
                                        input int file, input int target, input logic last);
        t_read r;
        r.kind     = kind;
        r.indel    = 8'(indel);
        r.rev      = rev;
        r.ref_sym  = ref_sym;
        r.read_sym = read_sym;
        r.next_sym = next_sym;
        r.bq       = 6'(bq);
        r.fq       = 6'(fq);
        r.has_next = has_next;
        r.file     = 2'(file);
        r.target   = 2'(target);
        r.last     = last;
        return r;
    endfunction

    function automatic logic [2:0] random_symbol();
        if ($urandom_range(0, 9) == 0) return 3'($urandom_range(4, 7));
        return 3'($urandom_range(0, 3));
    endfunction

    function automatic t_read random_read(input logic [1:0] target, input bit closes);
        t_read       r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            r.kind = KIND_BASE;
        end else if (pick < 93) begin
            r.kind = KIND_DEL;
        end else if (pick < 98) begin
            r.kind = KIND_REDUNDANT;
        end else begin
            r.kind = KIND_UNUSED;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            r.indel = 8'sd0;
        end else if (pick < 80) begin
            r.indel = 8'sd1;
        end else begin
            r.indel = 8'(int'($urandom_range(0, 128)) - 64);
        end
        r.rev      = 1'($urandom_range(0, 1));
        r.ref_sym  = random_symbol();
        r.read_sym = random_symbol();
        r.next_sym = random_symbol();
        r.bq       = 6'($urandom_range(0, 63));
        r.fq       = 6'($urandom_range(0, 63));
        r.has_next = 1'($urandom_range(0, 1));
        r.file     = 2'($urandom_range(0, 3));
        r.target   = target;
        r.last     = closes;
        if ($urandom_range(0, 11) == 0) begin
            r.target = 2'($urandom_range(0, 3));
            r.last   = 1'($urandom_range(0, 1));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_total++;
        $display("mismatch on %s at update %0d: expected %0h, got %0h", what,
                 updates_checked, want, got);
    endtask

    task automatic check_update();
        rehc_pkg::t_result want;
        if (pending_updates.size() == 0) begin
            report_mismatch("update with nothing expected", '0, out_ch.new_count);
            return;
        end
        want = pending_updates.pop_front();
        if (out_ch.update_kind !== want.kind)
            report_mismatch("update_kind", want.kind, out_ch.update_kind);
        if (out_ch.bin_file !== want.file)
            report_mismatch("bin_file", want.file, out_ch.bin_file);
        if (out_ch.bin_quality !== want.quality)
            report_mismatch("bin_quality", want.quality, out_ch.bin_quality);
        if (out_ch.first_symbol !== want.first)
            report_mismatch("first_symbol", want.first, out_ch.first_symbol);
        if (out_ch.second_symbol !== want.second)
            report_mismatch("second_symbol", want.second, out_ch.second_symbol);
        if (out_ch.coverage_value !== want.cov)
            report_mismatch("coverage_value", want.cov, out_ch.coverage_value);
        if (out_ch.new_count !== want.count)
            report_mismatch("new_count", want.count, out_ch.new_count);
        if (out_ch.last_result !== want.last)
            report_mismatch("last_result", want.last, out_ch.last_result);
        updates_checked++;
        if (want.kind == rehc_pkg::UPD_COVERAGE) coverage_updates++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) check_update();
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                out_ch.ready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(1, 17) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Valid is left high after a request is taken, so that back-to-back
    // requests never lower and raise it within one step.
    task automatic send_read(input t_read r);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.align_kind        <= r.kind;
        in_ch.indel_len         <= r.indel;
        in_ch.reverse_strand    <= r.rev;
        in_ch.ref_symbol        <= r.ref_sym;
        in_ch.read_symbol       <= r.read_sym;
        in_ch.following_symbol  <= r.next_sym;
        in_ch.base_quality      <= r.bq;
        in_ch.following_quality <= r.fq;
        in_ch.has_following     <= r.has_next;
        in_ch.file_index        <= r.file;
        in_ch.target_index      <= r.target;
        in_ch.last_of_position  <= r.last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_updates(r);
        reads_sent++;
    endtask

    task automatic wait_for_updates();
        in_ch.valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_read(make_read(KIND_BASE, 0, 0, SYM_A, SYM_A, SYM_A, 0, 0, 1, 0, 0, 0));
        send_read(make_read(KIND_BASE, 0, 1, SYM_C, SYM_T, SYM_A, 63, 63, 1, 3, 0, 0));
        send_read(make_read(KIND_BASE, 1, 0, SYM_G, SYM_G, SYM_T, 63, 0, 0, 1, 0, 0));
        send_read(make_read(KIND_BASE, 1, 0, SYM_T, SYM_N, SYM_C, 10, 20, 1, 2, 0, 0));
        send_read(make_read(KIND_BASE, 0, 1, SYM_N, SYM_A, SYM_A, 5, 6, 1, 0, 0, 0));
        send_read(make_read(KIND_BASE, 0, 0, SYM_GAP, SYM_C, SYM_A, 33, 2, 0, 1, 0, 0));
        send_read(make_read(KIND_BASE, 1, 0, SYM_A, SYM_C, SYM_JUNK, 12, 13, 0, 2, 0, 0));
        send_read(make_read(KIND_DEL, 0, 0, SYM_C, SYM_A, SYM_A, 30, 40, 1, 1, 0, 0));
        send_read(make_read(KIND_DEL, 0, 1, SYM_C, SYM_A, SYM_A, 30, 40, 1, 1, 0, 0));
        send_read(make_read(KIND_DEL, 1, 0, SYM_A, SYM_A, SYM_G, 7, 9, 1, 2, 0, 0));
        send_read(make_read(KIND_DEL, -64, 0, SYM_T, SYM_C, SYM_C, 50, 51, 1, 3, 0, 0));
        send_read(make_read(KIND_BASE, 64, 0, SYM_G, SYM_JUNK, SYM_A, 1, 2, 1, 0, 0, 0));
        send_read(make_read(KIND_BASE, -1, 1, SYM_G, SYM_C, SYM_T, 44, 45, 1, 3, 0, 1));
        send_read(make_read(KIND_REDUNDANT, 0, 0, SYM_A, SYM_A, SYM_A, 3, 3, 0, 3, 3, 0));
        send_read(make_read(KIND_BASE, 0, 0, SYM_T, SYM_G, SYM_A, 8, 8, 0, 3, 3, 1));
        send_read(make_read(KIND_UNUSED, 1, 0, SYM_A, SYM_C, SYM_G, 9, 9, 1, 0, 1, 1));
        send_read(make_read(KIND_DEL, 0, 0, SYM_T, SYM_A, SYM_A, 20, 21, 1, 2, 2, 1));
        send_read(make_read(KIND_BASE, 0, 0, SYM_A, SYM_T, SYM_A, 27, 0, 0, 3, 3, 1));
        send_read(make_read(KIND_BASE, 0, 0, SYM_A, SYM_T, SYM_A, 27, 0, 0, 3, 3, 1));
        send_read(make_read(KIND_DEL, 1, 1, SYM_G, SYM_A, SYM_GAP, 4, 5, 1, 1, 1, 0));
        send_read(make_read(KIND_BASE, 1, 1, SYM_A, SYM_G, SYM_C, 62, 61, 1, 2, 1, 1));
        wait_for_updates();
    endtask

    task automatic test_output_backpressure();
        gaps_on       = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < HOLD_READS; i++) begin
            send_read(random_read(2'(i % 4), (i % 3) == 2));
        end
        wait_for_updates();
        gaps_on = 1'b1;
    endtask

    task automatic test_coverage_saturation();
        t_read r;
        for (int i = 0; i < DEEP_READS; i++) begin
            r = make_read(KIND_BASE, 0, 0, SYM_C, SYM_N, SYM_A, 15, 16, 1, 1, 2,
                          i == DEEP_READS - 1);
            if (i % 40 == 0) r.read_sym = SYM_G;
            send_read(r);
        end
        wait_for_updates();
    endtask

    task automatic test_random_positions();
        int unsigned sent;
        int unsigned depth;
        logic [1:0]  target;
        sent = 0;
        while (sent < RANDOM_READS) begin
            if (sent >= RANDOM_READS - CALM_READS) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            depth  = $urandom_range(1, 8);
            target = 2'($urandom_range(0, 3));
            for (int i = 0; i < depth; i++) begin
                send_read(random_read(target, i == depth - 1));
                sent++;
            end
        end
        wait_for_updates();
    endtask

    initial begin
        i_rst_n                 <= 1'b0;
        in_ch.valid             <= 1'b0;
        in_ch.align_kind        <= KIND_BASE;
        in_ch.indel_len         <= '0;
        in_ch.reverse_strand    <= 1'b0;
        in_ch.ref_symbol        <= SYM_A;
        in_ch.read_symbol       <= SYM_A;
        in_ch.following_symbol  <= SYM_A;
        in_ch.base_quality      <= '0;
        in_ch.following_quality <= '0;
        in_ch.has_following     <= 1'b0;
        in_ch.file_index        <= '0;
        in_ch.target_index      <= '0;
        in_ch.last_of_position  <= 1'b0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        long_hold_req = 1'b0;
        clear_histograms();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_output_backpressure();
        test_coverage_saturation();
        test_random_positions();

        $display("%0d reads sent, %0d histogram updates checked, %0d of them coverage bins",
                 reads_sent, updates_checked, coverage_updates);
        $display("covered both strands, gaps, indels, redundant reads, saturation, %0d-cycle hold",
                 LONG_HOLD);
        if (mismatch_total == 0) begin
            $display("read_error_histogram_counter_test: done, clean");
        end else begin
            $display("read_error_histogram_counter_test: done, errors");
        end
        $finish;
    end

endmodule
